/* hdl/mqf_pkg.sv */
// Shared types and constants for the message queue FIFO.
// Used by the top level and its port checker; depends on nothing else.
package mqf_pkg;

  localparam int DATA_W    = 8;
  localparam int LEN_W     = 7;
  localparam int CFG_MSG_W = 5;
  localparam int CFG_W     = 7;
  localparam int STATUS_W  = 2;
  localparam int OUT_CNT_W = 5;
  localparam int CFG_IDX_W = 1;

  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
  localparam logic [STATUS_W-1:0] ST_TOO_LONG = 2'd2;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd3;

  localparam logic OP_SEND    = 1'b0;
  localparam logic OP_RECEIVE = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_MAX_MESSAGES = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_LENGTH   = 1'd1;

  localparam logic [CFG_MSG_W-1:0] MAX_MESSAGES_RESET = 5'd16;
  localparam logic [LEN_W-1:0]     MAX_LENGTH_RESET   = 7'd64;
  localparam logic [LEN_W-1:0]     BYTE_COUNT_SAT     = 7'd127;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LEN,
    S_DATA
  } mqf_state_t;

endpackage

/* hdl/mqf_ram.sv */
// Generic simple dual-port RAM: one write port, one registered read port.
// Read data holds its value while the read enable is low. No dependencies.
module mqf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* hdl/message_queue_fifo.sv */
// Message queue FIFO: a mailbox of SLOT_COUNT slots of up to MAX_MSG_BYTES bytes.
// Send bytes are taken one per cycle while no receive is in progress; a closing send also
// needs a free output register and gives its status result in the next cycle. A receive
// reads the length, then the first byte, then delivers one byte per cycle while the output
// is taken, set by the single read port of the byte memory. Synchronous reset clears
// pointers, counts and error and loads the configuration defaults; memories are not cleared.
module message_queue_fifo #(
  parameter int SLOT_COUNT    = 16,
  parameter int MAX_MSG_BYTES = 64
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [mqf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mqf_pkg::CFG_W-1:0]      cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           opcode,
  input  logic [mqf_pkg::DATA_W-1:0]     data_byte,
  input  logic                           byte_present,
  input  logic                           last_byte,
  input  logic [mqf_pkg::LEN_W-1:0]      receive_limit,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [mqf_pkg::STATUS_W-1:0]   status,
  output logic [mqf_pkg::DATA_W-1:0]     out_byte,
  output logic                           out_byte_valid,
  output logic                           last_result,
  output logic [mqf_pkg::LEN_W-1:0]      message_length,
  output logic [mqf_pkg::OUT_CNT_W-1:0]  message_count
);

  import mqf_pkg::*;

  localparam int SLOT_W    = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int BYTE_W    = (MAX_MSG_BYTES > 1) ? $clog2(MAX_MSG_BYTES) : 1;
  localparam int CNT_W     = $clog2(SLOT_COUNT + 1);
  localparam int MSG_DEPTH = SLOT_COUNT * (2 ** BYTE_W);
  localparam int MADDR_W   = SLOT_W + BYTE_W;
  localparam int CMP_W     = (CNT_W > CFG_MSG_W) ? CNT_W : CFG_MSG_W;

  localparam logic [SLOT_W-1:0] LAST_SLOT  = SLOT_W'(SLOT_COUNT - 1);
  localparam logic [CNT_W-1:0]  FULL_COUNT = CNT_W'(SLOT_COUNT);
  localparam logic [LEN_W-1:0]  MAX_BYTES  = LEN_W'(MAX_MSG_BYTES);

  mqf_state_t state, state_next;

  logic [CFG_MSG_W-1:0] max_messages;
  logic [LEN_W-1:0]     max_message_length;
  logic [SLOT_W-1:0]    read_slot, read_slot_next;
  logic [SLOT_W-1:0]    write_slot, write_slot_next;
  logic [CNT_W-1:0]     held_count, held_count_next;
  logic [LEN_W-1:0]     send_byte_count, send_byte_count_next;
  logic                 send_error, send_error_next;
  logic [LEN_W-1:0]     rx_limit, rx_limit_next;
  logic [LEN_W-1:0]     rx_count, rx_count_next;
  logic [LEN_W-1:0]     rx_index, rx_index_next;

  logic                 out_load;
  logic [STATUS_W-1:0]  status_next;
  logic [DATA_W-1:0]    out_byte_next;
  logic                 out_byte_valid_next;
  logic                 last_result_next;
  logic [LEN_W-1:0]     message_length_next;
  logic [OUT_CNT_W-1:0] message_count_next;

  // Memory ports.
  logic                 msg_we, msg_re;
  logic [MADDR_W-1:0]   msg_waddr, msg_raddr;
  logic [DATA_W-1:0]    msg_rdata;
  logic                 len_we, len_re;
  logic [LEN_W-1:0]     len_wdata, len_rdata;

  // Decode of the current request and queue state.
  logic                 out_free, is_send, closes, accept, slots_full;
  logic [LEN_W-1:0]     count_inc, eff_len, len_clip, rx_n, index_inc;
  logic                 error_any, limit_hit, too_long, commit, rx_last;
  logic [SLOT_W-1:0]    read_slot_inc, write_slot_inc;

  mqf_ram #(.WIDTH(DATA_W), .DEPTH(MSG_DEPTH)) u_msg_ram (
    .clk   (clk),
    .we    (msg_we),
    .waddr (msg_waddr),
    .wdata (data_byte),
    .re    (msg_re),
    .raddr (msg_raddr),
    .rdata (msg_rdata)
  );

  mqf_ram #(.WIDTH(LEN_W), .DEPTH(SLOT_COUNT)) u_len_ram (
    .clk   (clk),
    .we    (len_we),
    .waddr (write_slot),
    .wdata (len_wdata),
    .re    (len_re),
    .raddr (read_slot),
    .rdata (len_rdata)
  );

  always_comb begin
    out_free   = !out_valid || out_ready;
    is_send    = (opcode == OP_SEND);
    closes     = !is_send || last_byte;
    // A send byte that does not close its message yields no result, so it
    // need not wait for the output register.
    in_ready   = (state == S_IDLE) && (out_free || !closes);
    accept     = in_valid && in_ready;
    slots_full = (held_count == FULL_COUNT);

    if (byte_present && (send_byte_count != BYTE_COUNT_SAT)) begin
      count_inc = send_byte_count + LEN_W'(1);
    end else begin
      count_inc = send_byte_count;
    end
    error_any = send_error || (byte_present && slots_full);
    eff_len   = (max_message_length > MAX_BYTES) ? MAX_BYTES : max_message_length;
    limit_hit = (CMP_W'(held_count) >= CMP_W'(max_messages)) || slots_full;
    too_long  = count_inc > eff_len;
    commit    = !too_long && !error_any && !limit_hit;

    len_clip  = (len_rdata > MAX_BYTES) ? MAX_BYTES : len_rdata;
    rx_n      = (len_clip > rx_limit) ? rx_limit : len_clip;
    index_inc = rx_index + LEN_W'(1);
    rx_last   = (index_inc == rx_count);

    read_slot_inc  = (read_slot == LAST_SLOT) ? '0 : read_slot + SLOT_W'(1);
    write_slot_inc = (write_slot == LAST_SLOT) ? '0 : write_slot + SLOT_W'(1);
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept && !is_send && (held_count != '0)) begin
          state_next = S_LEN;
        end
      end
      S_LEN: begin
        if (rx_n != '0) begin
          state_next = S_DATA;
        end else if (out_free) begin
          state_next = S_IDLE;
        end
      end
      S_DATA: begin
        if (out_free && rx_last) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Datapath control and result formation.
  always_comb begin
    msg_we               = 1'b0;
    msg_waddr            = {write_slot, send_byte_count[BYTE_W-1:0]};
    msg_re               = 1'b0;
    msg_raddr            = {read_slot, {BYTE_W{1'b0}}};
    len_we               = 1'b0;
    len_wdata            = count_inc;
    len_re               = 1'b0;
    read_slot_next       = read_slot;
    write_slot_next      = write_slot;
    held_count_next      = held_count;
    send_byte_count_next = send_byte_count;
    send_error_next      = send_error;
    rx_limit_next        = rx_limit;
    rx_count_next        = rx_count;
    rx_index_next        = rx_index;
    out_load             = 1'b0;
    status_next          = ST_OK;
    out_byte_next        = '0;
    out_byte_valid_next  = 1'b0;
    last_result_next     = 1'b1;
    message_length_next  = '0;
    message_count_next   = OUT_CNT_W'(held_count);

    case (state)
      S_IDLE: begin
        if (accept && is_send) begin
          msg_we = byte_present && !slots_full && (send_byte_count < MAX_BYTES);
          if (!last_byte) begin
            send_byte_count_next = count_inc;
            send_error_next      = error_any;
          end else begin
            send_byte_count_next = '0;
            send_error_next      = 1'b0;
            out_load             = 1'b1;
            if (too_long) begin
              status_next = ST_TOO_LONG;
            end else if (!commit) begin
              status_next = ST_FULL;
            end else begin
              len_we              = 1'b1;
              write_slot_next     = write_slot_inc;
              held_count_next     = held_count + CNT_W'(1);
              message_length_next = count_inc;
              message_count_next  = OUT_CNT_W'(held_count + CNT_W'(1));
            end
          end
        end else if (accept) begin
          if (held_count == '0) begin
            out_load           = 1'b1;
            status_next        = ST_EMPTY;
            message_count_next = '0;
          end else begin
            len_re        = 1'b1;
            rx_limit_next = receive_limit;
          end
        end
      end
      S_LEN: begin
        // The pop is counted here so that every byte reports the count after it.
        if (rx_n != '0) begin
          msg_re          = 1'b1;
          rx_count_next   = rx_n;
          rx_index_next   = '0;
          held_count_next = held_count - CNT_W'(1);
        end else if (out_free) begin
          out_load           = 1'b1;
          held_count_next    = held_count - CNT_W'(1);
          read_slot_next     = read_slot_inc;
          message_count_next = OUT_CNT_W'(held_count - CNT_W'(1));
        end
      end
      S_DATA: begin
        if (out_free) begin
          out_load            = 1'b1;
          out_byte_next       = msg_rdata;
          out_byte_valid_next = 1'b1;
          last_result_next    = rx_last;
          message_length_next = rx_count;
          if (rx_last) begin
            read_slot_next = read_slot_inc;
          end else begin
            msg_re        = 1'b1;
            msg_raddr     = {read_slot, index_inc[BYTE_W-1:0]};
            rx_index_next = index_inc;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state              <= S_IDLE;
      max_messages       <= MAX_MESSAGES_RESET;
      max_message_length <= MAX_LENGTH_RESET;
      read_slot          <= '0;
      write_slot         <= '0;
      held_count         <= '0;
      send_byte_count    <= '0;
      send_error         <= 1'b0;
      out_valid          <= 1'b0;
    end else begin
      state           <= state_next;
      read_slot       <= read_slot_next;
      write_slot      <= write_slot_next;
      held_count      <= held_count_next;
      send_byte_count <= send_byte_count_next;
      send_error      <= send_error_next;
      if (cfg_write) begin
        case (cfg_index)
          CFG_MAX_MESSAGES: max_messages       <= cfg_data[CFG_MSG_W-1:0];
          CFG_MAX_LENGTH:   max_message_length <= cfg_data[LEN_W-1:0];
          default: begin
          end
        endcase
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    rx_limit <= rx_limit_next;
    rx_count <= rx_count_next;
    rx_index <= rx_index_next;
    if (out_load) begin
      status         <= status_next;
      out_byte       <= out_byte_next;
      out_byte_valid <= out_byte_valid_next;
      last_result    <= last_result_next;
      message_length <= message_length_next;
      message_count  <= message_count_next;
    end
  end

endmodule

/* hdl/mqf_checker.sv */
// Port-level checker for the message queue FIFO, bound to the top level.
// Depends on mqf_pkg for field widths and status codes.
module mqf_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           cfg_write,
  input logic [mqf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input logic [mqf_pkg::CFG_W-1:0]      cfg_data,
  input logic                           in_valid,
  input logic                           in_ready,
  input logic                           opcode,
  input logic [mqf_pkg::DATA_W-1:0]     data_byte,
  input logic                           byte_present,
  input logic                           last_byte,
  input logic [mqf_pkg::LEN_W-1:0]      receive_limit,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic [mqf_pkg::STATUS_W-1:0]   status,
  input logic [mqf_pkg::DATA_W-1:0]     out_byte,
  input logic                           out_byte_valid,
  input logic                           last_result,
  input logic [mqf_pkg::LEN_W-1:0]      message_length,
  input logic [mqf_pkg::OUT_CNT_W-1:0]  message_count
);

  import mqf_pkg::*;

  // A result that is not taken must hold still.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(status)
      && $stable(message_length) && $stable(last_result))
    else $error("result changed while stalled");

  // An empty receive reports no message and closes its request.
  a_empty: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_EMPTY) |->
      (message_count == '0) && !out_byte_valid && last_result && (message_length == '0))
    else $error("malformed empty-queue result");

  // A delivered byte belongs to a successful, non-empty delivery.
  a_byte: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_byte_valid |-> (status == ST_OK) && (message_length != '0))
    else $error("delivered byte with bad status or length");

  // Results without data are always the only result of their request.
  a_single: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_byte_valid |-> last_result)
    else $error("data-less result not marked last");

  // Nothing is offered right after reset.
  a_reset: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind message_queue_fifo mqf_checker u_mqf_checker (.*);

/* dv/message_queue_fifo_checker.sv */
`timescale 1ns / 1ps
// Reply checker for the message queue FIFO: tracks register writes and accepted requests,
// predicts every reply from its own copy of the mailbox and compares replies field by field.
// Depends on mqf_pkg for widths, status codes, opcodes and register indexes.
module message_queue_fifo_checker #(
  parameter int SLOT_COUNT    = 16,
  parameter int MAX_MSG_BYTES = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [mqf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mqf_pkg::CFG_W-1:0]     cfg_data,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  logic                          opcode,
  input  logic [mqf_pkg::DATA_W-1:0]    data_byte,
  input  logic                          byte_present,
  input  logic                          last_byte,
  input  logic [mqf_pkg::LEN_W-1:0]     receive_limit,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  logic [mqf_pkg::STATUS_W-1:0]  status,
  input  logic [mqf_pkg::DATA_W-1:0]    out_byte,
  input  logic                          out_byte_valid,
  input  logic                          last_result,
  input  logic [mqf_pkg::LEN_W-1:0]     message_length,
  input  logic [mqf_pkg::OUT_CNT_W-1:0] message_count,
  output int                            outstanding,
  output int                            failures
);
  import mqf_pkg::*;

  typedef struct packed {
    logic [STATUS_W-1:0]  status;
    logic [DATA_W-1:0]    data;
    logic                 data_ok;
    logic                 last;
    logic [LEN_W-1:0]     length;
    logic [OUT_CNT_W-1:0] count;
  } reply_t;

  logic [DATA_W-1:0] slot_bytes [SLOT_COUNT][MAX_MSG_BYTES];
  int                slot_len   [SLOT_COUNT];
  int                rd_slot;
  int                wr_slot;
  int                held;
  int                byte_count;
  bit                bytes_lost;
  int                cap_messages;
  int                cap_length;
  reply_t            due_replies [$];

  initial begin
    failures    = 0;
    outstanding = 0;
  end

  task automatic queue_reply(input logic [STATUS_W-1:0] st, input logic [DATA_W-1:0] data,
                             input logic data_ok, input logic last, input int length,
                             input int count);
    reply_t r;
    r.status  = st;
    r.data    = data;
    r.data_ok = data_ok;
    r.last    = last;
    r.length  = LEN_W'(length);
    r.count   = OUT_CNT_W'(count);
    due_replies.push_back(r);
  endtask

  // Advances the mailbox by one accepted request and queues the replies it causes.
  task automatic mailbox_step(input logic op, input logic [DATA_W-1:0] data,
                              input logic present, input logic close,
                              input logic [LEN_W-1:0] limit);
    int                  eff_len;
    int                  eff_max;
    int                  n;
    int                  slot;
    int                  i;
    logic [STATUS_W-1:0] st;
    if (op == OP_SEND) begin
      if (present) begin
        if (held >= SLOT_COUNT) begin
          bytes_lost = 1'b1;
        end else if (byte_count < MAX_MSG_BYTES) begin
          slot_bytes[wr_slot][byte_count] = data;
        end
        if (byte_count < int'(BYTE_COUNT_SAT)) byte_count++;
      end
      if (close) begin
        eff_len = (cap_length > MAX_MSG_BYTES) ? MAX_MSG_BYTES : cap_length;
        eff_max = (cap_messages > SLOT_COUNT) ? SLOT_COUNT : cap_messages;
        n = 0;
        // Too long wins over full.
        if (byte_count > eff_len) begin
          st = ST_TOO_LONG;
        end else if (bytes_lost || held >= eff_max) begin
          st = ST_FULL;
        end else begin
          st = ST_OK;
          n = byte_count;
          slot_len[wr_slot] = n;
          wr_slot = (wr_slot + 1) % SLOT_COUNT;
          held++;
        end
        byte_count = 0;
        bytes_lost = 1'b0;
        queue_reply(st, '0, 1'b0, 1'b1, n, held);
      end
    end else if (held == 0) begin
      queue_reply(ST_EMPTY, '0, 1'b0, 1'b1, 0, 0);
    end else begin
      slot = rd_slot;
      n = slot_len[slot];
      if (n > MAX_MSG_BYTES) n = MAX_MSG_BYTES;
      if (n > int'(limit)) n = int'(limit);
      rd_slot = (rd_slot + 1) % SLOT_COUNT;
      held--;
      if (n == 0) begin
        queue_reply(ST_OK, '0, 1'b0, 1'b1, 0, held);
      end else begin
        for (i = 0; i < n; i++) begin
          queue_reply(ST_OK, slot_bytes[slot][i], 1'b1, i == n - 1, n, held);
        end
      end
    end
  endtask

  task automatic compare_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      failures++;
    end
  endtask

  task automatic check_reply();
    reply_t r;
    if (due_replies.size() == 0) begin
      $error("reply with no request waiting: status %0d, byte %0d, count %0d",
             status, out_byte, message_count);
      failures++;
    end else begin
      r = due_replies.pop_front();
      compare_field("status", 8'(r.status), 8'(status));
      compare_field("out_byte", r.data, out_byte);
      compare_field("out_byte_valid", 8'(r.data_ok), 8'(out_byte_valid));
      compare_field("last_result", 8'(r.last), 8'(last_result));
      compare_field("message_length", 8'(r.length), 8'(message_length));
      compare_field("message_count", 8'(r.count), 8'(message_count));
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      rd_slot      = 0;
      wr_slot      = 0;
      held         = 0;
      byte_count   = 0;
      bytes_lost   = 1'b0;
      cap_messages = int'(MAX_MESSAGES_RESET);
      cap_length   = int'(MAX_LENGTH_RESET);
      due_replies.delete();
    end else begin
      // Replies are taken before new requests so that a reply arriving on the same edge
      // as a request can never match that request's own expectations.
      if (out_valid && out_ready) check_reply();
      if (cfg_write) begin
        case (cfg_index)
          CFG_MAX_MESSAGES: cap_messages = int'(cfg_data[CFG_MSG_W-1:0]);
          CFG_MAX_LENGTH:   cap_length   = int'(cfg_data);
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        mailbox_step(opcode, data_byte, byte_present, last_byte, receive_limit);
      end
    end
    outstanding <= due_replies.size();
  end

endmodule

/* dv/tb_message_queue_fifo.sv */
`timescale 1ns / 1ps
// Testbench top for the message queue FIFO: drives directed and random send and receive
// requests with random idling, and gives the verdict. Depends on mqf_pkg, the block and
// message_queue_fifo_checker.
module tb_message_queue_fifo;
  import mqf_pkg::*;

  localparam int RANDOM_ITEMS = 160;
  localparam int PHASES       = 6;
  localparam int SETTLE       = 8;

  logic                 clk           = 1'b0;
  logic                 rst           = 1'b1;
  logic                 cfg_write     = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index     = CFG_MAX_MESSAGES;
  logic [CFG_W-1:0]     cfg_data      = '0;
  logic                 in_valid      = 1'b0;
  logic                 in_ready;
  logic                 opcode        = OP_SEND;
  logic [DATA_W-1:0]    data_byte     = '0;
  logic                 byte_present  = 1'b0;
  logic                 last_byte     = 1'b0;
  logic [LEN_W-1:0]     receive_limit = '0;
  logic                 out_valid;
  logic                 out_ready     = 1'b1;
  logic [STATUS_W-1:0]  status;
  logic [DATA_W-1:0]    out_byte;
  logic                 out_byte_valid;
  logic                 last_result;
  logic [LEN_W-1:0]     message_length;
  logic [OUT_CNT_W-1:0] message_count;

  int outstanding;
  int failures;
  int items = 0;
  bit steady = 1'b0;

  message_queue_fifo DUT (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .opcode(opcode), .data_byte(data_byte), .byte_present(byte_present),
    .last_byte(last_byte), .receive_limit(receive_limit),
    .out_valid(out_valid), .out_ready(out_ready),
    .status(status), .out_byte(out_byte), .out_byte_valid(out_byte_valid),
    .last_result(last_result), .message_length(message_length),
    .message_count(message_count)
  );

  message_queue_fifo_checker replies_chk (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .opcode(opcode), .data_byte(data_byte), .byte_present(byte_present),
    .last_byte(last_byte), .receive_limit(receive_limit),
    .out_valid(out_valid), .out_ready(out_ready),
    .status(status), .out_byte(out_byte), .out_byte_valid(out_byte_valid),
    .last_result(last_result), .message_length(message_length),
    .message_count(message_count),
    .outstanding(outstanding), .failures(failures)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    out_ready <= steady || ($urandom_range(99) >= 7);
  end

  initial begin
    #10_000_000;
    $display("message_queue_fifo verification failed");
    $finish;
  end

  // Presents one request and returns on the edge where it is taken. Valid is left high so
  // that back-to-back requests keep it asserted.
  task automatic push(input logic op, input logic [DATA_W-1:0] data, input logic present,
                      input logic close, input logic [LEN_W-1:0] limit);
    if (!steady && $urandom_range(99) < 7) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
    in_valid      <= 1'b1;
    opcode        <= op;
    data_byte     <= data;
    byte_present  <= present;
    last_byte     <= close;
    receive_limit <= limit;
    do @(posedge clk); while (in_ready !== 1'b1);
    if (op == OP_RECEIVE || present || close) items++;
  endtask

  task automatic receive(input int limit);
    push(OP_RECEIVE, DATA_W'($urandom), 1'($urandom), 1'($urandom), LEN_W'(limit));
  endtask

  // Streams a message of len random bytes. With mix set, a receive or an ignored request
  // may land in the middle of the message.
  task automatic send_message(input int len, input bit empty_close, input bit mix);
    int i;
    for (i = 0; i < len; i++) begin
      if (mix && $urandom_range(99) < 4) receive($urandom_range(64));
      if (mix && $urandom_range(99) < 4) begin
        push(OP_SEND, DATA_W'($urandom), 1'b0, 1'b0, LEN_W'($urandom_range(64)));
      end
      push(OP_SEND, DATA_W'($urandom), 1'b1, (i == len - 1) && !empty_close,
           LEN_W'($urandom_range(64)));
    end
    if (len == 0 || empty_close) begin
      push(OP_SEND, DATA_W'($urandom), 1'b0, 1'b1, LEN_W'($urandom_range(64)));
    end
  endtask

  // Holds the sender until every predicted reply has come, then lets the block settle.
  task automatic drain(input int settle);
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (settle) @(posedge clk);
  endtask

  task automatic set_register(input logic [CFG_IDX_W-1:0] idx, input int value);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_W'(value);
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  function automatic int pick_length();
    int r;
    r = $urandom_range(99);
    if (r < 60) return $urandom_range(8);
    if (r < 90) return $urandom_range(40, 9);
    return $urandom_range(70, 41);
  endfunction

  function automatic int pick_from(input int a, input int b, input int c, input int d,
                                   input int top);
    case ($urandom_range(4))
      0: return a;
      1: return b;
      2: return c;
      3: return d;
      default: return $urandom_range(top);
    endcase
  endfunction

  initial begin
    int p;
    int r;
    int bias;
    int phase_end;
    int base;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty queue, empty messages, byte extremes, truncation, zero limit and
    // a receive in the middle of a send.
    receive(64);
    push(OP_SEND, 8'h00, 1'b0, 1'b0, 7'd0);
    push(OP_SEND, 8'hFF, 1'b0, 1'b1, 7'd64);
    push(OP_SEND, 8'h00, 1'b1, 1'b0, 7'd0);
    push(OP_SEND, 8'hFF, 1'b1, 1'b0, 7'd64);
    push(OP_SEND, 8'h5A, 1'b1, 1'b1, 7'd1);
    push(OP_SEND, 8'hA5, 1'b1, 1'b0, 7'd0);
    push(OP_SEND, 8'h00, 1'b0, 1'b1, 7'd0);
    receive(64);
    receive(2);
    push(OP_SEND, 8'h3C, 1'b1, 1'b0, 7'd0);
    receive(0);
    push(OP_SEND, 8'hC3, 1'b1, 1'b1, 7'd0);
    receive(64);
    receive(64);
    drain(SETTLE);

    // Tightest limits: a single byte is too long even while the queue is also full.
    set_register(CFG_MAX_MESSAGES, 1);
    set_register(CFG_MAX_LENGTH, 0);
    send_message(0, 1'b0, 1'b0);
    send_message(1, 1'b0, 1'b0);
    send_message(0, 1'b0, 1'b0);
    receive(64);
    drain(SETTLE);

    // Register values above the slot count and byte capacity act as those limits.
    set_register(CFG_MAX_MESSAGES, 31);
    set_register(CFG_MAX_LENGTH, 127);
    send_message(65, 1'b0, 1'b0);
    send_message(64, 1'b0, 1'b0);
    receive(64);
    send_message(130, 1'b0, 1'b0);
    repeat (16) send_message($urandom_range(3, 1), 1'b0, 1'b0);
    // Every slot is taken: bytes are lost and the close reports full, even after a
    // receive frees a slot in the middle of the message.
    send_message(2, 1'b0, 1'b0);
    push(OP_SEND, 8'h11, 1'b1, 1'b0, 7'd0);
    receive(64);
    push(OP_SEND, 8'h22, 1'b1, 1'b1, 7'd0);
    drain(SETTLE);

    set_register(CFG_MAX_MESSAGES, 0);
    send_message(1, 1'b0, 1'b0);
    send_message(0, 1'b0, 1'b0);
    drain(SETTLE);

    base = items;
    for (p = 0; p < PHASES; p++) begin
      set_register(CFG_MAX_MESSAGES, pick_from(0, 1, 16, 31, 31));
      set_register(CFG_MAX_LENGTH, pick_from(0, 1, 64, 127, 127));
      steady <= (p == 2);
      bias = $urandom_range(75, 35);
      phase_end = base + RANDOM_ITEMS * (p + 1) / PHASES;
      while (items < phase_end) begin
        r = $urandom_range(99);
        if (r < bias) begin
          send_message(pick_length(), $urandom_range(99) < 15, 1'b1);
        end else if (r < 97) begin
          receive(($urandom_range(1) == 1) ? 64 : $urandom_range(64));
        end else begin
          push(OP_SEND, DATA_W'($urandom), 1'b0, 1'b0, LEN_W'($urandom_range(64)));
        end
        // One pause in the middle of a phase, without touching the registers.
        if (p == 3 && items == (phase_end + base + RANDOM_ITEMS * p / PHASES) / 2) begin
          drain(0);
        end
      end
      drain(SETTLE);
    end

    drain(20);
    if (failures == 0) begin
      $display("message_queue_fifo verification clean");
    end else begin
      $display("message_queue_fifo verification failed");
    end
    $finish;
  end

endmodule
